FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int CODE_UNIT_BITS = 16;
    localparam int UNIT_W = 16;
    localparam logic [UNIT_W-1:0] UNIT_MASK = UNIT_W'((64'd1 << CODE_UNIT_BITS) - 64'd1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [UNIT_W-1:0] CH_QUOTE = UNIT_W'(34);
    localparam logic [UNIT_W-1:0] CH_BSLASH = UNIT_W'(92);
    localparam logic [UNIT_W-1:0] CH_SLASH = UNIT_W'(47);
    localparam logic [UNIT_W-1:0] CH_N = UNIT_W'(110);
    localparam logic [UNIT_W-1:0] CH_T = UNIT_W'(116);
    localparam logic [UNIT_W-1:0] CH_R = UNIT_W'(114);
    localparam logic [UNIT_W-1:0] CH_B = UNIT_W'(98);
    localparam logic [UNIT_W-1:0] CH_F = UNIT_W'(102);
    localparam logic [UNIT_W-1:0] CH_U = UNIT_W'(117);
    localparam logic [UNIT_W-1:0] CH_LF = UNIT_W'(10);
    localparam logic [UNIT_W-1:0] CH_TAB = UNIT_W'(9);
    localparam logic [UNIT_W-1:0] CH_CR = UNIT_W'(13);
    localparam logic [UNIT_W-1:0] CH_BS = UNIT_W'(8);
    localparam logic [UNIT_W-1:0] CH_FF = UNIT_W'(12);
    localparam logic [UNIT_W-1:0] CH_0 = UNIT_W'(48);
    localparam logic [UNIT_W-1:0] CH_9 = UNIT_W'(57);
    localparam logic [UNIT_W-1:0] CH_LA = UNIT_W'(97);
    localparam logic [UNIT_W-1:0] CH_LF_HEX = UNIT_W'(102);
    localparam logic [UNIT_W-1:0] CH_UA = UNIT_W'(65);
    localparam logic [UNIT_W-1:0] CH_UF = UNIT_W'(70);

    typedef enum logic [2:0] {
        ST_CHAR       = 3'd0,
        ST_END        = 3'd1,
        ST_EXPECTED   = 3'd2,
        ST_UNTERM     = 3'd3,
        ST_UNTERM_ESC = 3'd4,
        ST_BAD_U      = 3'd5,
        ST_BAD_ESC    = 3'd6
    } status_t;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_BODY  = 5'b00010,
        MODE_ESC   = 5'b00100,
        MODE_HEX   = 5'b01000,
        MODE_DRAIN = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        status_t           status;
        logic              two;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic [QLVL_W-1:0] level;
    } qstat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [UNIT_W-1:0] u);
        hex_t r;
        r.ok = 1'b1;
        r.value = 4'd0;
        if (u >= CH_0 && u <= CH_9)
        begin
            r.value = 4'(u - CH_0);
        end
        else if (u >= CH_LA && u <= CH_LF_HEX)
        begin
            r.value = 4'(u - CH_LA + UNIT_W'(10));
        end
        else if (u >= CH_UA && u <= CH_UF)
        begin
            r.value = 4'(u - CH_UA + UNIT_W'(10));
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [jsu_pkg::UNIT_W-1:0] code_unit,
    input  logic                    last_unit,
    output jsu_pkg::push_t          push
);
    import jsu_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [UNIT_W-1:0] acc_reg, acc_next;
    logic [UNIT_W-1:0] u;
    hex_t              hv;
    push_t             p;

    assign u = code_unit & UNIT_MASK;
    assign hv = hex_value(u);

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        p.valid = 1'b0;
        p.job.unit = '0;
        p.job.status = ST_CHAR;
        p.job.two = 1'b0;
        case (mode_reg)
            MODE_BODY:
            begin
                if (u == CH_QUOTE)
                begin
                    mode_next = MODE_IDLE;
                    p.valid = 1'b1;
                    p.job.status = ST_END;
                end
                else if (u == CH_BSLASH)
                begin
                    if (last_unit)
                    begin
                        mode_next = MODE_IDLE;
                        p.valid = 1'b1;
                        p.job.status = ST_UNTERM_ESC;
                    end
                    else
                    begin
                        mode_next = MODE_ESC;
                    end
                end
                else
                begin
                    p.valid = 1'b1;
                    p.job.unit = u;
                    p.job.two = last_unit;
                    mode_next = last_unit ? MODE_IDLE : MODE_BODY;
                end
            end
            MODE_ESC:
            begin
                p.valid = 1'b1;
                p.job.two = last_unit;
                mode_next = last_unit ? MODE_IDLE : MODE_BODY;
                case (u)
                    CH_QUOTE:  p.job.unit = CH_QUOTE;
                    CH_BSLASH: p.job.unit = CH_BSLASH;
                    CH_SLASH:  p.job.unit = CH_SLASH;
                    CH_N:      p.job.unit = CH_LF;
                    CH_T:      p.job.unit = CH_TAB;
                    CH_R:      p.job.unit = CH_CR;
                    CH_B:      p.job.unit = CH_BS;
                    CH_F:      p.job.unit = CH_FF;
                    CH_U:
                    begin
                        p.job.two = 1'b0;
                        if (last_unit)
                        begin
                            p.job.status = ST_BAD_U;
                        end
                        else
                        begin
                            p.valid = 1'b0;
                            cnt_next = 2'd0;
                            acc_next = '0;
                            mode_next = MODE_HEX;
                        end
                    end
                    default:
                    begin
                        p.job.two = 1'b0;
                        p.job.status = ST_BAD_ESC;
                        mode_next = last_unit ? MODE_IDLE : MODE_DRAIN;
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (!hv.ok)
                begin
                    p.valid = 1'b1;
                    p.job.status = ST_BAD_U;
                    mode_next = last_unit ? MODE_IDLE : MODE_DRAIN;
                end
                else
                begin
                    acc_next = {acc_reg[UNIT_W-5:0], hv.value};
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next = 2'd0;
                        p.valid = 1'b1;
                        p.job.unit = acc_next;
                        p.job.two = last_unit;
                        mode_next = last_unit ? MODE_IDLE : MODE_BODY;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        if (last_unit)
                        begin
                            p.valid = 1'b1;
                            p.job.status = ST_BAD_U;
                            mode_next = MODE_IDLE;
                        end
                    end
                end
            end
            MODE_DRAIN:
            begin
                if (last_unit)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                if (u == CH_QUOTE)
                begin
                    if (last_unit)
                    begin
                        mode_next = MODE_IDLE;
                        p.valid = 1'b1;
                        p.job.status = ST_UNTERM;
                    end
                    else
                    begin
                        mode_next = MODE_BODY;
                    end
                end
                else
                begin
                    p.valid = 1'b1;
                    p.job.status = ST_EXPECTED;
                    mode_next = last_unit ? MODE_IDLE : MODE_DRAIN;
                end
            end
        endcase
    end

    assign push.valid = accept && p.valid;
    assign push.job = p.job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg <= 2'd0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: hdl/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  jsu_pkg::push_t push,
    input  logic           pop,
    output jsu_pkg::job_t  head,
    output jsu_pkg::qstat_t stat
);
    import jsu_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QLVL_W-1:0] lvl_reg, lvl_next;
    logic              do_push, do_pop;

    assign do_push = push.valid && (lvl_reg != QLVL_W'(QDEPTH));
    assign do_pop = pop && (lvl_reg != '0);

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        lvl_next = lvl_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            lvl_next = lvl_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            lvl_next = lvl_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    assign head = mem[rd_reg];
    assign stat.full = (lvl_reg == QLVL_W'(QDEPTH));
    assign stat.empty = (lvl_reg == '0);
    assign stat.level = lvl_reg;

endmodule

FILE: hdl/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  jsu_pkg::job_t              head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [jsu_pkg::UNIT_W-1:0] m_tdata,
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast
);
    import jsu_pkg::*;

    logic              valid_reg, valid_next;
    logic              second_reg, second_next;
    logic [UNIT_W-1:0] data_reg, data_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;
    logic              load;

    assign load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        second_next = second_reg;
        data_next = data_reg;
        status_next = status_reg;
        last_next = last_reg;
        pop = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                valid_next = 1'b1;
                second_next = 1'b0;
                data_next = '0;
                status_next = ST_UNTERM;
                last_next = 1'b1;
            end
            else if (!empty)
            begin
                pop = 1'b1;
                valid_next = 1'b1;
                second_next = head.two;
                data_next = (head.status == ST_CHAR) ? head.unit : '0;
                status_next = head.status;
                last_next = !head.two;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        status_reg <= status_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tuser = status_reg;
    assign m_tlast = last_reg;

endmodule

FILE: hdl/json_string_unescape_top.sv
// path: a result passes through the queue and output register to the master
// throughput: one input beat per cycle unless the queue is full; a two-result
//   beat is absorbed by a four-entry queue between front and back
// reset: rst_n asynchronous active low, decoder returns to waiting for a quote,
//   queue and output register empty
`timescale 1ns / 1ps

module json_string_unescape_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_unit
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // decoded_unit
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);
    import jsu_pkg::*;

    logic   accept;
    push_t  push;
    job_t   head;
    qstat_t stat;
    logic   pop;

    assign s_tready = !stat.full;
    assign accept = s_tvalid && s_tready;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (s_tdata),
        .last_unit (s_tlast),
        .push      (push)
    );

    jsu_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    jsu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (stat.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.level <= QLVL_W'(QDEPTH))
        else $error("queue level beyond depth");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_CHAR) |-> m_tdata == '0)
        else $error("nonzero data on status beat");

    a_first_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == ST_CHAR)
        else $error("non-final beat is not a character");

    a_second_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && (m_tuser == ST_UNTERM))
        else $error("character not followed by unterminated status");

endmodule
